// ----- src/bia_pkg.sv -----
// Shared constants and types for the bitmap id allocator.
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

	localparam int ID_W          = 12;
	localparam int KIND_W        = 2;
	localparam int ID_SPACE      = 4096;
	localparam int NUM_IDS_DEF   = 4096;
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_MARK  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            found;
	} bia_res_t;

endpackage

`default_nettype wire

// ----- src/bia_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/bia_first_free.sv -----
// Lowest set bit search over one bitmap word of candidate free ids.
`timescale 1ns / 1ps
`default_nettype none

module bia_first_free #(
	parameter int SW   = 32,
	localparam int LGW = $clog2(SW)
) (
	input  wire logic [SW-1:0]  cand,
	output logic                hit,
	output logic      [LGW-1:0] idx
);

	always_comb begin
		idx = '0;
		// scan from the top so the lowest candidate wins
		for (int i = SW - 1; i >= 0; i--) begin
			if (cand[i]) begin
				idx = LGW'(i);
			end
		end
		hit = |cand;
	end

endmodule

`default_nettype wire

// ----- src/bitmap_id_allocator_top.sv -----
// Top level: bitmap id allocator that scans upward from a hint id, with a word-serial scan sequencer.
// Allocate scans one word at a time from the hint word until a free id or the last word; mark reads
//   the id's word once; no-op and out-of-range items go straight to the result; clear sweeps first.
// One item at a time: in_stall is high from acceptance until the result is registered.
// Reset and the clear item sweep the bitmap RAM one word per cycle (all NUM_WORDS words,
//   128 at the defaults); in_stall stays high during the sweep.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_id_allocator_top #(
	parameter int NUM_IDS   = bia_pkg::NUM_IDS_DEF,
	parameter int WORD_BITS = bia_pkg::WORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [bia_pkg::KIND_W-1:0]   kind,
	input  wire logic [bia_pkg::ID_W-1:0]     id,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [bia_pkg::ID_W-1:0]     result_id,
	output logic                              found,
	output logic      [bia_pkg::ID_W-1:0]     high_mark
);

	localparam int ID_W     = bia_pkg::ID_W;
	localparam int ID_LIMIT = (NUM_IDS < bia_pkg::ID_SPACE) ? NUM_IDS : bia_pkg::ID_SPACE;
	// word width rounded down to a power of two so an id splits into word and bit fields
	localparam int LGW       = $clog2(WORD_BITS + 1) - 1;
	localparam int SW        = 1 << LGW;
	localparam int NUM_WORDS = (ID_LIMIT + SW - 1) / SW;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int LAST_BITS = ID_LIMIT - (NUM_WORDS - 1) * SW;
	localparam logic [AW-1:0]   LAST_WORD = AW'(NUM_WORDS - 1);
	localparam logic [SW-1:0]   LAST_MASK = {SW{1'b1}} >> (SW - LAST_BITS);
	localparam logic [ID_W:0]   LIMIT_X   = (ID_W + 1)'(ID_LIMIT);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   pend_q;
	logic [AW-1:0] clr_q;
	logic [ID_W-1:0] hm_q;
	logic [ID_W-1:0] res_id_q;
	logic            res_found_q;
	logic [ID_W-1:0] out_id_q;
	logic            out_found_q;
	logic [ID_W-1:0] out_hm_q;
	logic            out_valid_q;

	bia_pkg::kind_t  kind_q;
	logic [ID_W-1:0] id_q;
	logic [AW-1:0]   word_q;
	logic            first_q;

	logic            in_xfer;
	logic            out_xfer;
	logic            out_load;
	logic            in_range;
	logic [AW-1:0]   raddr;
	logic [SW-1:0]   rdata;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [SW-1:0]   wdata;
	logic [SW-1:0]   cand;
	logic            hit;
	logic [LGW-1:0]  hit_idx;
	logic [LGW-1:0]  bit_sel;
	logic [ID_W-1:0] hit_id;
	logic            mark_free;
	logic            last_word;
	bia_pkg::bia_res_t scan_res;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign out_load  = (state_q == S_RESULT) && (!out_valid_q || !out_stall);
	assign in_range  = ({1'b0, id} < LIMIT_X);
	assign last_word = (word_q == LAST_WORD);
	assign mark_free = !rdata[id_q[LGW-1:0]];
	assign hit_id    = ID_W'({word_q, hit_idx});

	assign out_valid = out_valid_q;
	assign result_id = out_id_q;
	assign found     = out_found_q;
	assign high_mark = out_hm_q;

	always_comb begin
		if (state_q == S_IDLE) begin
			raddr = id[LGW+AW-1:LGW];
		end else begin
			raddr = word_q + AW'(1);
		end
	end

	always_comb begin
		cand = ~rdata;
		if (first_q) begin
			cand = cand & ({SW{1'b1}} << id_q[LGW-1:0]);
		end
		if (last_word) begin
			cand = cand & LAST_MASK;
		end
	end

	bia_first_free #(
		.SW (SW)
	) u_first_free (
		.cand (cand),
		.hit  (hit),
		.idx  (hit_idx)
	);

	always_comb begin
		bit_sel = (kind_q == bia_pkg::KIND_MARK) ? id_q[LGW-1:0] : hit_idx;
		we      = 1'b0;
		waddr   = word_q;
		wdata   = rdata | (SW'(1) << bit_sel);
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_SCAN: begin
				we = (kind_q == bia_pkg::KIND_MARK) ? mark_free : hit;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (kind_q == bia_pkg::KIND_MARK) begin
			scan_res.id    = id_q;
			scan_res.found = mark_free;
		end else if (hit) begin
			scan_res.id    = hit_id;
			scan_res.found = 1'b1;
		end else begin
			scan_res.id    = id_q;
			scan_res.found = 1'b0;
		end
	end

	bia_ram #(
		.WIDTH (SW),
		.DEPTH (NUM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// item context, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= bia_pkg::kind_t'(kind);
			id_q    <= id;
			word_q  <= id[LGW+AW-1:LGW];
			first_q <= 1'b1;
		end else if (state_q == S_SCAN && kind_q == bia_pkg::KIND_ALLOC
				&& !hit && !last_word) begin
			word_q  <= word_q + AW'(1);
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pend_q      <= 1'b0;
			clr_q       <= '0;
			hm_q        <= '0;
			res_id_q    <= '0;
			res_found_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_id_q    <= '0;
			out_found_q <= 1'b0;
			out_hm_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == LAST_WORD) begin
						clr_q   <= '0;
						state_q <= pend_q ? S_RESULT : S_IDLE;
						pend_q  <= 1'b0;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						res_found_q <= 1'b0;
						unique case (kind)
							bia_pkg::KIND_ALLOC,
							bia_pkg::KIND_MARK: begin
								res_id_q <= id;
								state_q  <= in_range ? S_SCAN : S_RESULT;
							end
							bia_pkg::KIND_CLEAR: begin
								hm_q     <= '0;
								res_id_q <= '0;
								pend_q   <= 1'b1;
								clr_q    <= '0;
								state_q  <= S_CLEAR;
							end
							default: begin
								res_id_q <= id;
								state_q  <= S_RESULT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (kind_q == bia_pkg::KIND_MARK || hit || last_word) begin
						res_id_q    <= scan_res.id;
						res_found_q <= scan_res.found;
						state_q     <= S_RESULT;
						if (kind_q == bia_pkg::KIND_ALLOC && hit && hit_id > hm_q) begin
							hm_q <= hit_id;
						end
					end
				end
				S_RESULT: begin
					if (out_load) begin
						out_id_q    <= res_id_q;
						out_found_q <= res_found_q;
						out_hm_q    <= hm_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> ({1'b0, result_id} < LIMIT_X))
		else $error("found result outside id range");

	a_hm_rises_only: assert property (@(posedge clk) disable iff (!arst_n)
		(hm_q != $past(hm_q) && hm_q != '0) |-> (hm_q > $past(hm_q)))
		else $error("high mark moved down without a clear");

	a_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_CLEAR || state_q == S_SCAN))
		else $error("bitmap written outside clear or scan");

	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_RESULT))
		else $error("result transfer raised without a finished item");
`endif

endmodule

`default_nettype wire
